[rtl/core/qrmpw_pkg.sv]
package qrmpw_pkg;

   localparam int COORD_W = 5;

   // symbol geometry
   localparam int SIDE_V1  = 21;
   localparam int SIDE_V2  = SIDE_V1 + 4;
   localparam int ALIGN_LO = 16;
   localparam int ALIGN_HI = 20;

   // stream packing
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic load;      // accept an input beat
      logic advance;   // step the walker one position
      logic emit;      // capture the result into the output register
   } qrmpw_cmd_type;

   typedef struct packed {
      logic exhausted; // walker ran off column 0
      logic reserved;  // current position is a function module
   } qrmpw_status_type;

endpackage

[rtl/core/qrmpw_ctrl.sv]
module qrmpw_ctrl
   import qrmpw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  qrmpw_status_type status,
   output qrmpw_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic place_now;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign place_now = status.exhausted || !status.reserved;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (place_now) begin
               // hold until the output register can take the result
               if (out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.advance = !status.exhausted;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/qrmpw_datapath.sv]
module qrmpw_datapath
   import qrmpw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  qrmpw_cmd_type        cmd,
   input  logic                 in_bit,
   input  logic                 in_restart,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_wdata,
   output qrmpw_status_type     status,
   output logic [COORD_W-1:0]   out_column,
   output logic [COORD_W-1:0]   out_row,
   output logic                 out_bit,
   output logic                 out_overflow
);

   localparam logic [1:0] PH_UP_L = 2'd0;
   localparam logic [1:0] PH_UP_R = 2'd1;
   localparam logic [1:0] PH_DN_L = 2'd2;
   localparam logic [1:0] PH_DN_R = 2'd3;

   localparam logic [COORD_W-1:0] V1_LAST  = COORD_W'(SIDE_V1 - 1);
   localparam logic [COORD_W-1:0] V2_LAST  = COORD_W'(SIDE_V2 - 1);
   localparam logic [COORD_W-1:0] V1_FAR   = COORD_W'(SIDE_V1 - 8);
   localparam logic [COORD_W-1:0] V2_FAR   = COORD_W'(SIDE_V2 - 8);
   localparam logic [COORD_W-1:0] EDGE8    = COORD_W'(8);
   localparam logic [COORD_W-1:0] TIMING   = COORD_W'(6);
   localparam logic [COORD_W-1:0] COL7     = COORD_W'(7);
   localparam logic [COORD_W-1:0] COL5     = COORD_W'(5);
   localparam logic [COORD_W-1:0] AL_LO    = COORD_W'(ALIGN_LO);
   localparam logic [COORD_W-1:0] AL_HI    = COORD_W'(ALIGN_HI);

   logic [1:0]         ver_ff, ver_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [1:0]         ph_ff, ph_in;
   logic               exh_ff, exh_in;
   logic               bit_ff;
   logic [COORD_W-1:0] out_col_ff, out_row_ff;
   logic               out_bit_ff, out_ovf_ff;

   logic [COORD_W-1:0] last_idx, far_lo;
   logic               reserved;

   logic signed [COORD_W+1:0] nc_s, nr_s, c_s, r_s;
   logic [1:0]                nph;
   logic [COORD_W-1:0]        adv_col, adv_row;
   logic                      adv_exh;
   logic                      reload;
   logic [COORD_W-1:0]        reload_idx;

   // side-dependent bounds; version codes 2 and 3 both select the larger symbol
   assign last_idx = ver_ff[1] ? V2_LAST : V1_LAST;
   assign far_lo   = ver_ff[1] ? V2_FAR  : V1_FAR;

   always_comb begin
      reserved = 1'b0;
      if (col_ff <= EDGE8 && row_ff <= EDGE8)  reserved = 1'b1;
      if (col_ff <= EDGE8 && row_ff >= far_lo) reserved = 1'b1;
      if (col_ff >= far_lo && row_ff <= EDGE8) reserved = 1'b1;
      if (col_ff == TIMING || row_ff == TIMING) reserved = 1'b1;
      if (ver_ff[1] && col_ff >= AL_LO && col_ff <= AL_HI &&
          row_ff >= AL_LO && row_ff <= AL_HI) reserved = 1'b1;
   end

   assign status.exhausted = exh_ff;
   assign status.reserved  = reserved;

   // one walker step
   always_comb begin
      c_s  = signed'({2'b00, col_ff});
      r_s  = signed'({2'b00, row_ff});
      nc_s = c_s;
      nr_s = r_s;
      nph  = ph_ff;
      if (row_ff == '0 && ph_ff == PH_UP_R) begin
         // top of an upward strip: next strip, skipping the timing column
         nc_s = (col_ff == COL7) ? signed'({2'b00, COL5}) : c_s - 7'sd1;
         nph  = PH_DN_L;
      end else if (row_ff == last_idx && ph_ff == PH_DN_R) begin
         nc_s = c_s - 7'sd1;
         nph  = PH_UP_L;
      end else begin
         unique case (ph_ff)
            PH_UP_L: begin
               nc_s = c_s - 7'sd1;
               nph  = PH_UP_R;
            end
            PH_UP_R: begin
               nc_s = c_s + 7'sd1;
               nr_s = r_s - 7'sd1;
               nph  = PH_UP_L;
            end
            PH_DN_L: begin
               nc_s = c_s - 7'sd1;
               nph  = PH_DN_R;
            end
            PH_DN_R: begin
               nc_s = c_s + 7'sd1;
               nr_s = r_s + 7'sd1;
               nph  = PH_DN_L;
            end
            default: nph = PH_UP_L;
         endcase
      end

      if (nr_s < 0) begin
         adv_row = '0;
      end else if (nr_s > signed'({2'b00, last_idx})) begin
         adv_row = last_idx;
      end else begin
         adv_row = nr_s[COORD_W-1:0];
      end

      adv_exh = exh_ff;
      if (nc_s < 0) begin
         adv_exh = 1'b1;
         adv_col = '0;
      end else if (nc_s > signed'({2'b00, last_idx})) begin
         adv_col = last_idx;
      end else begin
         adv_col = nc_s[COORD_W-1:0];
      end
   end

   assign reload     = csr_wen || (cmd.load && in_restart);
   assign reload_idx = csr_wen ? (csr_wdata[1] ? V2_LAST : V1_LAST) : last_idx;

   always_comb begin
      ver_in = csr_wen ? csr_wdata : ver_ff;
      col_in = col_ff;
      row_in = row_ff;
      ph_in  = ph_ff;
      exh_in = exh_ff;
      priority if (reload) begin
         col_in = reload_idx;
         row_in = reload_idx;
         ph_in  = PH_UP_L;
         exh_in = 1'b0;
      end else if (cmd.advance) begin
         col_in = adv_col;
         row_in = adv_row;
         ph_in  = nph;
         exh_in = adv_exh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff <= 2'd1;
         col_ff <= V1_LAST;
         row_ff <= V1_LAST;
         ph_ff  <= PH_UP_L;
         exh_ff <= 1'b0;
      end else begin
         ver_ff <= ver_in;
         col_ff <= col_in;
         row_ff <= row_in;
         ph_ff  <= ph_in;
         exh_ff <= exh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bit_ff <= in_bit;
      end
      if (cmd.emit) begin
         out_col_ff <= exh_ff ? '0 : col_ff;
         out_row_ff <= exh_ff ? '0 : row_ff;
         out_bit_ff <= exh_ff ? 1'b0 : bit_ff;
         out_ovf_ff <= exh_ff;
      end
   end

   assign out_column   = out_col_ff;
   assign out_row      = out_row_ff;
   assign out_bit      = out_bit_ff;
   assign out_overflow = out_ovf_ff;

endmodule

[rtl/core/qr_module_placement_walker_unit.sv]
// Places codeword bits into a version 1 (21x21) or version 2 (25x25) QR symbol:
// each request beat carries one bit and yields one response beat with the column
// and row of the module that receives it, walking two-column zigzag strips from
// the bottom-right corner and passing over finder, separator, format, timing,
// dark-module and (version 2) alignment areas. The walker steps over reserved
// modules one per cycle, waits with a placed bit while the response register is
// still full, and handles one bit at a time. tuser on the request restarts the
// walk at the corner before the bit is placed; writing csr_wdata selects the
// version and also restarts the walk. Once the walk runs past column 0 every
// response has tuser (overflow) set and zero coordinates until a restart.
module qr_module_placement_walker_unit
   import qrmpw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] data_bit, rest zero
   input  logic                  req_tuser,  // [0] restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [4:0] module_column, [9:5] module_row,
                                             // [10] module_bit, rest zero
   output logic                  rsp_tuser,  // [0] overflow
   input  logic                  csr_wen,
   input  logic [1:0]            csr_wdata   // symbol_version
);

   qrmpw_cmd_type      cmd;
   qrmpw_status_type   status;
   logic [COORD_W-1:0] out_column, out_row;
   logic               out_bit, out_overflow;

   qrmpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qrmpw_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_bit       (req_tdata[0]),
      .in_restart   (req_tuser),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .status       (status),
      .out_column   (out_column),
      .out_row      (out_row),
      .out_bit      (out_bit),
      .out_overflow (out_overflow)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 2*COORD_W - 1){1'b0}}, out_bit, out_row, out_column};
   assign rsp_tuser = out_overflow;

endmodule
